// ----- hw/rtl/gff_pkg.sv -----
package gff_pkg;

    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 7;

    localparam logic [CFG_IDX_W-1:0] CFG_NUM_ROWS = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_COLS = 1'd1;

    localparam logic [1:0] MODE_WRITE = 2'd0;
    localparam logic [1:0] MODE_FILL  = 2'd1;

    localparam logic [12:0] COUNT_MAX = 13'h1fff;

    typedef struct packed {
        logic [1:0] mode;
        logic [5:0] row;
        logic [5:0] col;
        logic [7:0] cell_char;
    } item_t;

    typedef struct packed {
        logic [7:0]  old_char;
        logic [12:0] cells_changed;
        logic        out_of_range;
    } result_t;

    // controller to datapath
    typedef struct packed {
        logic capture;
        logic seed_cap;
        logic seed_wr;
        logic set_one;
        logic fill_begin;
        logic pop;
        logic load_cur;
        logic nb_rd;
        logic nb_visit;
        logic nb_adv;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic       oor;
        logic [1:0] mode;
        logic       seed_eq;
        logic       sp_zero;
        logic       nb_valid;
        logic       nb_match;
        logic       nb_last;
    } status_t;

endpackage

// ----- hw/rtl/gff_ctrl.sv -----
module gff_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  gff_pkg::status_t sts,
    output gff_pkg::cmd_t   cmd,
    output logic            busy,
    output logic            done
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEED,
        ST_POP,
        ST_POP_WAIT,
        ST_NB_CHECK,
        ST_NB_CMP
    } state_t;

    state_t state_reg;
    logic   done_reg;

    assign busy = (state_reg != ST_IDLE);
    assign done = done_reg;

    always_comb
    begin
        cmd = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                cmd.capture = start;
            end
            ST_SEED:
            begin
                cmd.seed_cap = 1'b1;
                if (sts.mode == gff_pkg::MODE_WRITE)
                begin
                    cmd.seed_wr = 1'b1;
                    cmd.set_one = 1'b1;
                end
                else if (sts.mode == gff_pkg::MODE_FILL && !sts.seed_eq)
                begin
                    cmd.seed_wr    = 1'b1;
                    cmd.set_one    = 1'b1;
                    cmd.fill_begin = 1'b1;
                end
            end
            ST_POP:
            begin
                cmd.pop = !sts.sp_zero;
            end
            ST_POP_WAIT:
            begin
                cmd.load_cur = 1'b1;
            end
            ST_NB_CHECK:
            begin
                cmd.nb_rd  = sts.nb_valid;
                cmd.nb_adv = !sts.nb_valid && !sts.nb_last;
            end
            ST_NB_CMP:
            begin
                cmd.nb_visit = sts.nb_match;
                cmd.nb_adv   = !sts.nb_last;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (start)
                    begin
                        if (sts.oor)
                            done_reg <= 1'b1;
                        else
                            state_reg <= ST_SEED;
                    end
                end
                ST_SEED:
                begin
                    if (sts.mode == gff_pkg::MODE_FILL && !sts.seed_eq)
                        state_reg <= ST_POP;
                    else
                    begin
                        state_reg <= ST_IDLE;
                        done_reg  <= 1'b1;
                    end
                end
                ST_POP:
                begin
                    if (sts.sp_zero)
                    begin
                        state_reg <= ST_IDLE;
                        done_reg  <= 1'b1;
                    end
                    else
                        state_reg <= ST_POP_WAIT;
                end
                ST_POP_WAIT:
                begin
                    state_reg <= ST_NB_CHECK;
                end
                ST_NB_CHECK:
                begin
                    if (sts.nb_valid)
                        state_reg <= ST_NB_CMP;
                    else if (sts.nb_last)
                        state_reg <= ST_POP;
                end
                ST_NB_CMP:
                begin
                    state_reg <= sts.nb_last ? ST_POP : ST_NB_CHECK;
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.pop |-> !sts.sp_zero)
        else $error("pop from empty stack");

    a_visit_in_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.nb_visit |-> $past(cmd.nb_rd))
        else $error("neighbor visited without a read");

    a_finish_done: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> done)
        else $error("item finished without a result");

endmodule

// ----- hw/rtl/gff_datapath.sv -----
module gff_datapath #(
    parameter int MAX_ROWS = 64,
    parameter int MAX_COLS = 64
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  gff_pkg::item_t                    item,
    input  logic                              cfg_wr,
    input  logic [gff_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [gff_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  gff_pkg::cmd_t                     cmd,
    output gff_pkg::status_t                  sts,
    output gff_pkg::result_t                  result
);

    localparam int CELLS = MAX_ROWS * MAX_COLS;
    localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int CW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int AW = (CELLS > 1) ? $clog2(CELLS) : 1;
    localparam int PW = $clog2(CELLS + 1);
    localparam int SW = RW + CW;
    localparam logic [AW-1:0] COLS_A = AW'(MAX_COLS);

    localparam logic [1:0] NB_UP    = 2'd0;
    localparam logic [1:0] NB_DOWN  = 2'd1;
    localparam logic [1:0] NB_LEFT  = 2'd2;
    localparam logic [1:0] NB_RIGHT = 2'd3;

    logic [6:0] num_rows_reg, num_cols_reg;
    logic [6:0] nr, nc;

    logic [7:0]    grid_mem [CELLS];
    logic [7:0]    grid_q;
    logic [SW-1:0] stack_mem [CELLS];
    logic [SW-1:0] stack_q;
    logic [PW-1:0] sp_reg;

    logic [1:0]    mode_reg;
    logic [RW-1:0] seed_r_reg, cur_r_reg, nb_r;
    logic [CW-1:0] seed_c_reg, cur_c_reg, nb_c;
    logic [7:0]    ch_reg, from_reg;
    logic [1:0]    k_reg;
    logic [7:0]    old_reg;
    logic [12:0]   count_reg;
    logic          oor_reg;

    logic [RW-1:0] acc_r;
    logic [CW-1:0] acc_c;
    logic [AW-1:0] addr;
    logic          nb_ok;

    assign nr = (32'(num_rows_reg) > MAX_ROWS) ? 7'(MAX_ROWS) : num_rows_reg;
    assign nc = (32'(num_cols_reg) > MAX_COLS) ? 7'(MAX_COLS) : num_cols_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_rows_reg <= 7'd64;
            num_cols_reg <= 7'd64;
        end
        else if (cfg_wr)
        begin
            if (cfg_index == gff_pkg::CFG_NUM_ROWS)
                num_rows_reg <= cfg_data;
            else if (cfg_index == gff_pkg::CFG_NUM_COLS)
                num_cols_reg <= cfg_data;
        end
    end

    // neighbor of the popped cell and its bounds check
    always_comb
    begin
        nb_r  = cur_r_reg;
        nb_c  = cur_c_reg;
        nb_ok = 1'b0;
        unique case (k_reg)
            NB_UP:
            begin
                nb_r  = cur_r_reg - 1'b1;
                nb_ok = (cur_r_reg != '0);
            end
            NB_DOWN:
            begin
                nb_r  = cur_r_reg + 1'b1;
                nb_ok = (32'(cur_r_reg) + 1 < 32'(nr));
            end
            NB_LEFT:
            begin
                nb_c  = cur_c_reg - 1'b1;
                nb_ok = (cur_c_reg != '0);
            end
            NB_RIGHT:
            begin
                nb_c  = cur_c_reg + 1'b1;
                nb_ok = (32'(cur_c_reg) + 1 < 32'(nc));
            end
            default:
            begin
                nb_ok = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        priority if (cmd.capture)
        begin
            acc_r = RW'(item.row);
            acc_c = CW'(item.col);
        end
        else if (cmd.seed_wr)
        begin
            acc_r = seed_r_reg;
            acc_c = seed_c_reg;
        end
        else
        begin
            acc_r = nb_r;
            acc_c = nb_c;
        end
    end

    assign addr = AW'(AW'(acc_r) * COLS_A + AW'(acc_c));

    // grid: single port, registered read
    always_ff @(posedge clk)
    begin
        if (cmd.seed_wr)
            grid_mem[addr] <= ch_reg;
        else if (cmd.nb_visit)
            grid_mem[addr] <= ch_reg;
        if (cmd.capture || cmd.nb_rd)
            grid_q <= grid_mem[addr];
    end

    // fill stack
    always_ff @(posedge clk)
    begin
        if (cmd.fill_begin)
            stack_mem[sp_reg[AW-1:0]] <= {seed_r_reg, seed_c_reg};
        else if (cmd.nb_visit)
            stack_mem[sp_reg[AW-1:0]] <= {nb_r, nb_c};
        if (cmd.pop)
            stack_q <= stack_mem[AW'(sp_reg - 1'b1)];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sp_reg <= '0;
        else if (cmd.fill_begin || cmd.nb_visit)
            sp_reg <= sp_reg + 1'b1;
        else if (cmd.pop)
            sp_reg <= sp_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            mode_reg   <= item.mode;
            seed_r_reg <= RW'(item.row);
            seed_c_reg <= CW'(item.col);
            ch_reg     <= item.cell_char;
            old_reg    <= 8'd0;
            count_reg  <= 13'd0;
            oor_reg    <= sts.oor;
        end
        if (cmd.seed_cap)
            old_reg <= grid_q;
        if (cmd.set_one)
            count_reg <= 13'd1;
        else if (cmd.nb_visit && count_reg != gff_pkg::COUNT_MAX)
            count_reg <= count_reg + 1'b1;
        if (cmd.fill_begin)
            from_reg <= grid_q;
        if (cmd.load_cur)
        begin
            {cur_r_reg, cur_c_reg} <= stack_q;
            k_reg <= NB_UP;
        end
        else if (cmd.nb_adv)
            k_reg <= k_reg + 1'b1;
    end

    assign sts.oor      = ({1'b0, item.row} >= nr) || ({1'b0, item.col} >= nc);
    assign sts.mode     = mode_reg;
    assign sts.seed_eq  = (grid_q == ch_reg);
    assign sts.sp_zero  = (sp_reg == '0);
    assign sts.nb_valid = nb_ok;
    assign sts.nb_match = (grid_q == from_reg);
    assign sts.nb_last  = (k_reg == NB_RIGHT);

    assign result.old_char      = old_reg;
    assign result.cells_changed = count_reg;
    assign result.out_of_range  = oor_reg;

    a_sp_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(sp_reg) <= CELLS)
        else $error("fill stack overflow");

    a_push_then_pop: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.fill_begin |=> !sts.sp_zero)
        else $error("seed not on stack");

endmodule

// ----- hw/rtl/grid_flood_fill_top.sv -----
// character grid with 4-connected flood fill
//
// items enter on the command channel: a beat is taken when start is high and
// busy is low. mode 0 writes a cell, mode 1 fills from a seed cell, mode 2
// (and 3) reads a cell. each item gives exactly one result beat: done is high
// for one cycle with result valid in that cycle; the receiver cannot stall.
// grid size is set through the cfg channel (index 0 rows, 1 columns, 7-bit
// data, ready always high); write it only while the block is idle.
// an out-of-range address gives done in the cycle after the start beat; busy
// is never raised for it. for other items busy stays high until the result
// beat. a fill takes, per recolored cell, a pop, a stack read, then a grid
// read and compare per in-bounds neighbor on the single-port grid memory.
// after reset the grid contents are undefined until written, the stack is
// empty and the grid size is 64x64.
module grid_flood_fill_top #(
    parameter int MAX_ROWS = 64,
    parameter int MAX_COLS = 64
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  gff_pkg::item_t                  item,
    output logic                            busy,
    output logic                            done,
    output gff_pkg::result_t                result,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [gff_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [gff_pkg::CFG_DATA_W-1:0]  cfg_data
);

    gff_pkg::cmd_t    cmd;
    gff_pkg::status_t sts;

    assign cfg_ready = 1'b1;

    gff_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .sts   (sts),
        .cmd   (cmd),
        .busy  (busy),
        .done  (done)
    );

    gff_datapath #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item),
        .cfg_wr    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .sts       (sts),
        .result    (result)
    );

endmodule
